FILE: hw/rtl/ccc_pkg.sv
`default_nettype none

package ccc_pkg;

   localparam int unsigned CCC_EPOCH_YEAR = 2025;
   localparam int unsigned CCC_YEAR_BITS  = 12;

   localparam logic [5:0] SECONDS_PER_MIN = 6'd60;
   localparam logic [5:0] MINUTES_PER_HR  = 6'd60;
   localparam logic [4:0] HOURS_PER_DAY   = 5'd24;
   localparam logic [3:0] MONTH_JAN       = 4'd1;
   localparam logic [3:0] MONTH_FEB       = 4'd2;
   localparam logic [3:0] MONTH_DEC       = 4'd12;
   localparam logic [4:0] FEB_LEAP_DAYS   = 5'd29;

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_SET  = 1'b1
   } ccc_req_kind_type;

   typedef struct packed {
      ccc_req_kind_type req_type;
      logic [4:0]       set_hour;
      logic [5:0]       set_minute;
      logic [5:0]       set_second;
      logic [4:0]       set_day;
      logic [3:0]       set_month;
      logic [11:0]      set_year;
   } ccc_req_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [16:0] seconds_of_day;
      logic [19:0] day_count;
   } ccc_rsp_type;

   // time and date state, year kept apart since its width is a parameter
   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [16:0] sod;
      logic [19:0] day_count;
   } ccc_time_type;

   // days in a common year, month 1 to 12
   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the first n months of a common year, n from 0 to 12
   function automatic logic [8:0] days_before(input logic [3:0] n);
      logic [8:0] days;
      unique case (n)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         4'd12:   days = 9'd365;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/calendar_clock_counter.sv
`default_nettype none

// Real-time clock and calendar. Each req beat is either a one-second tick
// (counted only while the run enable bit written on the csr port is set) or
// a set request that loads hour, minute, second, day, month and year. Every
// req beat yields exactly one rsp beat showing time, date, seconds since
// midnight and the day count from 1 January of EPOCH_YEAR after that beat.
// A beat is taken into an input register, the next state is computed in one
// pass of combinational logic, and the state and the rsp register load
// together once the rsp slot is free: one beat per cycle sustained while
// rsp_ready stays high. The rsp register and the input register form a
// two-deep stage, so a new req beat is taken while a result waits. The
// year counts modulo 2^YEAR_BITS and the year field shows its low 12 bits;
// seconds_of_day and day_count wrap at their field widths. The run enable
// bit should only be written while no beat is in flight.
module calendar_clock_counter #(
   parameter int unsigned EPOCH_YEAR = ccc_pkg::CCC_EPOCH_YEAR,
   parameter int unsigned YEAR_BITS  = ccc_pkg::CCC_YEAR_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ccc_pkg::ccc_req_type req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ccc_pkg::ccc_rsp_type rsp_data,
   // run enable register
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);

   // input stage
   logic                  in_valid_ff, in_valid_in;
   ccc_pkg::ccc_req_type  req_ff, req_in;

   // clock state
   ccc_pkg::ccc_time_type time_ff, time_in;
   logic [YEAR_BITS-1:0]  year_ff, year_in;
   logic                  run_enable_ff, run_enable_in;

   // result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   ccc_pkg::ccc_rsp_type  rsp_data_ff, rsp_data_in;

   ccc_pkg::ccc_time_type time_nxt;
   logic [YEAR_BITS-1:0]  year_nxt;
   logic                  advance;
   logic                  retire;

   ccc_next #(
      .EPOCH_YEAR (EPOCH_YEAR),
      .YEAR_BITS  (YEAR_BITS)
   ) u_next (
      .req        (req_ff),
      .run_enable (run_enable_ff),
      .time_cur   (time_ff),
      .year_cur   (year_ff),
      .time_nxt   (time_nxt),
      .year_nxt   (year_nxt)
   );

   // result slot frees up when empty or being taken this cycle
   assign advance   = !rsp_valid_ff || rsp_ready;
   // the held beat commits its state change as it moves into the rsp slot
   assign retire    = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in   = in_valid_ff;
      req_in        = req_ff;
      time_in       = time_ff;
      year_in       = year_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      run_enable_in = run_enable_ff;

      if (csr_valid) begin
         run_enable_in = csr_data;
      end

      if (req_ready) begin
         in_valid_in = req_valid;
         req_in      = req_data;
      end

      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end

      if (retire) begin
         time_in                    = time_nxt;
         year_in                    = year_nxt;
         rsp_data_in.hour           = time_nxt.hour;
         rsp_data_in.minute         = time_nxt.minute;
         rsp_data_in.second         = time_nxt.second;
         rsp_data_in.day            = time_nxt.day;
         rsp_data_in.month          = time_nxt.month;
         rsp_data_in.year           = 12'(year_nxt);
         rsp_data_in.seconds_of_day = time_nxt.sod;
         rsp_data_in.day_count      = time_nxt.day_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         run_enable_ff     <= 1'b0;
         time_ff.hour      <= 5'd0;
         time_ff.minute    <= 6'd0;
         time_ff.second    <= 6'd0;
         time_ff.day       <= 5'd1;
         time_ff.month     <= ccc_pkg::MONTH_JAN;
         time_ff.sod       <= 17'd0;
         time_ff.day_count <= 20'd1;
         year_ff           <= YEAR_BITS'(EPOCH_YEAR);
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         run_enable_ff     <= run_enable_in;
         time_ff           <= time_in;
         year_ff           <= year_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // state only moves when a beat commits into the rsp slot
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !retire |=> $stable(time_ff) && $stable(year_ff))
      else $error("clock state changed without a committing beat");

   // a shown result always matches the live state
   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.day_count == time_ff.day_count
                    && rsp_data_ff.seconds_of_day == time_ff.sod
                    && rsp_data_ff.year == 12'(year_ff))
      else $error("rsp payload out of step with clock state");

   // back pressure only when both stages are full and the output is stalled
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("req stalled with room in the pipeline");

   // a tick while stopped leaves the clock alone
   a_stopped_tick: assert property (@(posedge clock) disable iff (reset)
      retire && req_ff.req_type == ccc_pkg::REQ_TICK && !run_enable_ff
      |=> $stable(time_ff) && $stable(year_ff))
      else $error("clock advanced while run enable was clear");

endmodule

`default_nettype wire

FILE: hw/rtl/ccc_next.sv
`default_nettype none

module ccc_next #(
   parameter int unsigned EPOCH_YEAR = ccc_pkg::CCC_EPOCH_YEAR,
   parameter int unsigned YEAR_BITS  = ccc_pkg::CCC_YEAR_BITS
) (
   input  ccc_pkg::ccc_req_type  req,
   input  logic                  run_enable,
   input  ccc_pkg::ccc_time_type time_cur,
   input  logic [YEAR_BITS-1:0]  year_cur,
   output ccc_pkg::ccc_time_type time_nxt,
   output logic [YEAR_BITS-1:0]  year_nxt
);

   localparam logic [31:0] EPOCH_W     = 32'(EPOCH_YEAR);
   localparam logic [31:0] EPOCH_LEAPS = 32'((EPOCH_YEAR + 3) / 4);

   // set path
   logic [YEAR_BITS-1:0] set_year_w;
   logic [31:0]          year_w;
   logic [31:0]          whole_days;
   logic [3:0]           months_done;
   logic [8:0]           month_days;
   logic                 set_leap_add;
   logic [16:0]          set_sod;
   logic [19:0]          set_dc;

   // tick path
   logic [6:0]           sec_inc;
   logic                 sec_carry;
   logic [6:0]           min_inc;
   logic                 min_carry;
   logic [5:0]           hr_inc;
   logic                 day_carry;
   logic [5:0]           day_inc;
   logic [4:0]           day_limit;
   logic                 month_known;
   logic                 month_over;
   ccc_pkg::ccc_time_type tick_time;
   logic [YEAR_BITS-1:0] tick_year;

   always_comb begin
      set_year_w = YEAR_BITS'(req.set_year);
      year_w     = 32'(set_year_w);
      if (year_w > EPOCH_W) begin
         whole_days = (year_w - EPOCH_W) * 32'd365 + ((year_w + 32'd3) >> 2) - EPOCH_LEAPS;
      end else begin
         whole_days = 32'd0;
      end
      if (req.set_month == 4'd0) begin
         months_done = 4'd0;
      end else if (req.set_month > ccc_pkg::MONTH_DEC) begin
         months_done = ccc_pkg::MONTH_DEC;
      end else begin
         months_done = req.set_month - 4'd1;
      end
      month_days   = ccc_pkg::days_before(months_done);
      set_leap_add = (months_done >= 4'd2) && (set_year_w[1:0] == 2'b00);
      set_sod      = 17'(req.set_second) + 17'(req.set_minute) * 17'd60
                   + 17'(req.set_hour) * 17'd3600;
      set_dc       = 20'(whole_days) + 20'(month_days) + 20'(set_leap_add)
                   + 20'(req.set_day);
   end

   always_comb begin
      sec_inc   = 7'(time_cur.second) + 7'd1;
      sec_carry = sec_inc >= 7'(ccc_pkg::SECONDS_PER_MIN);
      min_inc   = 7'(time_cur.minute) + 7'(sec_carry);
      min_carry = min_inc >= 7'(ccc_pkg::MINUTES_PER_HR);
      hr_inc    = 6'(time_cur.hour) + 6'(min_carry);
      day_carry = hr_inc >= 6'(ccc_pkg::HOURS_PER_DAY);
      day_inc   = 6'(time_cur.day) + 6'd1;

      month_known = (time_cur.month >= ccc_pkg::MONTH_JAN)
                 && (time_cur.month <= ccc_pkg::MONTH_DEC);
      if (time_cur.month == ccc_pkg::MONTH_FEB && year_cur[1:0] == 2'b00) begin
         day_limit = ccc_pkg::FEB_LEAP_DAYS;
      end else begin
         day_limit = ccc_pkg::month_len(time_cur.month);
      end
      month_over = month_known && (day_inc > 6'(day_limit));

      tick_time        = time_cur;
      tick_year        = year_cur;
      tick_time.second = sec_carry ? 6'd0 : sec_inc[5:0];
      tick_time.minute = min_carry ? 6'd0 : min_inc[5:0];
      tick_time.hour   = day_carry ? 5'd0 : hr_inc[4:0];
      tick_time.sod    = time_cur.sod + 17'd1;
      if (day_carry) begin
         tick_time.sod       = 17'd0;
         tick_time.day_count = time_cur.day_count + 20'd1;
         tick_time.day       = day_inc[4:0];
         if (month_over) begin
            tick_time.day = 5'd1;
            if (time_cur.month == ccc_pkg::MONTH_DEC) begin
               tick_time.month = ccc_pkg::MONTH_JAN;
               tick_year       = year_cur + YEAR_BITS'(1);
            end else begin
               tick_time.month = time_cur.month + 4'd1;
            end
         end
      end
   end

   always_comb begin
      time_nxt = time_cur;
      year_nxt = year_cur;
      if (req.req_type == ccc_pkg::REQ_SET) begin
         time_nxt.hour      = req.set_hour;
         time_nxt.minute    = req.set_minute;
         time_nxt.second    = req.set_second;
         time_nxt.day       = req.set_day;
         time_nxt.month     = req.set_month;
         time_nxt.sod       = set_sod;
         time_nxt.day_count = set_dc;
         year_nxt           = set_year_w;
      end else if (run_enable) begin
         time_nxt = tick_time;
         year_nxt = tick_year;
      end
   end

endmodule

`default_nettype wire

FILE: sim/tb_calendar_clock_counter.sv
`default_nettype none

module tb_calendar_clock_counter;
   timeunit 1ns;
   timeprecision 1ps;

   // the sink stops taking results for a long stretch once this many have arrived
   localparam int unsigned HOLD_AFTER_RESULTS = 60;
   localparam int unsigned HOLD_CYCLES        = 80;
   localparam int unsigned PHASES             = 6;

   typedef enum logic {
      STEP_BEAT = 1'b0,
      STEP_CSR  = 1'b1
   } step_kind_type;

   // one line of the directed sequence: a request beat or a run-enable write
   typedef struct packed {
      step_kind_type        kind;
      ccc_pkg::ccc_req_type beat;
      logic                 pinned;
      ccc_pkg::ccc_rsp_type readout;
      logic                 enable;
   } plan_row_type;

   // readout typed in by hand for a directed beat, used instead of the prediction
   typedef struct packed {
      logic                 pinned;
      ccc_pkg::ccc_rsp_type readout;
   } pinned_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   ccc_pkg::ccc_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   ccc_pkg::ccc_rsp_type rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_data;

   // predicted time and date, and the predicted run enable bit
   ccc_pkg::ccc_rsp_type wall_clock;
   logic                 run_on;

   // readouts still owed by the block, oldest first
   ccc_pkg::ccc_rsp_type pending_readouts[$];
   pinned_type           typed_readouts[$];

   int unsigned errors;
   int unsigned sets_taken;
   int unsigned ticks_taken;
   int unsigned results_seen;
   int unsigned enable_writes;
   int unsigned midnights;
   bit          quiet_tail;
   bit          hold_done;

   calendar_clock_counter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // calendar predictor
   // ------------------------------------------------------------------

   // days in month m of year y, leap rule is just year divisible by 4
   function automatic int unsigned month_days(input logic [3:0] m, input logic [11:0] y);
      case (m)
         ccc_pkg::MONTH_FEB:      return (y[1:0] == 2'b00) ? 29 : 28;
         4'd4, 4'd6, 4'd9, 4'd11: return 30;
         default:                 return 31;
      endcase
   endfunction

   // day number counted from 1 january of the epoch year, months summed one by one
   function automatic logic [19:0] days_from_epoch(input logic [4:0] d, input logic [3:0] m,
                                                   input logic [11:0] y);
      int unsigned total;
      int unsigned yr;
      int unsigned months;
      int unsigned i;
      yr    = 32'(y);
      total = 0;
      // years at or below the epoch add no whole years
      if (yr > ccc_pkg::CCC_EPOCH_YEAR)
         total = 365 * (yr - ccc_pkg::CCC_EPOCH_YEAR) + (yr + 3) / 4
               - (ccc_pkg::CCC_EPOCH_YEAR + 3) / 4;
      // month zero adds nothing, months past december add the whole year
      months = (m == 4'd0) ? 0 : 32'(m) - 1;
      if (months > 12)
         months = 12;
      for (i = 1; i <= months; i++)
         total += month_days(i[3:0], y);
      total += 32'(d);
      return total[19:0];
   endfunction

   // set request: fields load as given, derived counters recomputed
   function automatic ccc_pkg::ccc_rsp_type load_time(input ccc_pkg::ccc_req_type b);
      ccc_pkg::ccc_rsp_type nxt;
      int unsigned          sod;
      nxt.hour           = b.set_hour;
      nxt.minute         = b.set_minute;
      nxt.second         = b.set_second;
      nxt.day            = b.set_day;
      nxt.month          = b.set_month;
      nxt.year           = b.set_year;
      sod                = 32'(b.set_second) + 60 * 32'(b.set_minute)
                         + 3600 * 32'(b.set_hour);
      nxt.seconds_of_day = sod[16:0];
      nxt.day_count      = days_from_epoch(b.set_day, b.set_month, b.set_year);
      return nxt;
   endfunction

   // one-second tick with carries; counters at or past their limit wrap and carry
   function automatic ccc_pkg::ccc_rsp_type tick_forward(input ccc_pkg::ccc_rsp_type now);
      ccc_pkg::ccc_rsp_type nxt;
      int unsigned          sec;
      int unsigned          mnt;
      int unsigned          hr;
      int unsigned          dy;
      nxt = now;
      sec = 32'(now.second) + 1;
      mnt = 32'(now.minute);
      hr  = 32'(now.hour);
      dy  = 32'(now.day);
      nxt.seconds_of_day = now.seconds_of_day + 17'd1;
      if (sec >= 32'(ccc_pkg::SECONDS_PER_MIN)) begin
         sec = 0;
         mnt++;
      end
      if (mnt >= 32'(ccc_pkg::MINUTES_PER_HR)) begin
         mnt = 0;
         hr++;
      end
      if (hr >= 32'(ccc_pkg::HOURS_PER_DAY)) begin
         hr                 = 0;
         nxt.seconds_of_day = '0;
         nxt.day_count      = now.day_count + 20'd1;
         dy++;
         // with a month outside 1..12 the day just counts on modulo 32
         if (now.month >= ccc_pkg::MONTH_JAN && now.month <= ccc_pkg::MONTH_DEC) begin
            if (dy > month_days(now.month, now.year)) begin
               dy = 1;
               if (now.month == ccc_pkg::MONTH_DEC) begin
                  nxt.month = ccc_pkg::MONTH_JAN;
                  nxt.year  = now.year + 12'd1;
               end else begin
                  nxt.month = now.month + 4'd1;
               end
            end
         end
      end
      nxt.second = sec[5:0];
      nxt.minute = mnt[5:0];
      nxt.hour   = hr[4:0];
      nxt.day    = dy[4:0];
      return nxt;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic ccc_pkg::ccc_rsp_type readout_of(input int unsigned h,
                                                       input int unsigned m,
                                                       input int unsigned s,
                                                       input int unsigned d,
                                                       input int unsigned mo,
                                                       input int unsigned y,
                                                       input int unsigned sod,
                                                       input int unsigned dc);
      ccc_pkg::ccc_rsp_type r;
      r.hour           = 5'(h);
      r.minute         = 6'(m);
      r.second         = 6'(s);
      r.day            = 5'(d);
      r.month          = 4'(mo);
      r.year           = 12'(y);
      r.seconds_of_day = 17'(sod);
      r.day_count      = 20'(dc);
      return r;
   endfunction

   function automatic ccc_pkg::ccc_req_type set_beat(input int unsigned h,
                                                     input int unsigned m,
                                                     input int unsigned s,
                                                     input int unsigned d,
                                                     input int unsigned mo,
                                                     input int unsigned y);
      ccc_pkg::ccc_req_type b;
      b.req_type   = ccc_pkg::REQ_SET;
      b.set_hour   = 5'(h);
      b.set_minute = 6'(m);
      b.set_second = 6'(s);
      b.set_day    = 5'(d);
      b.set_month  = 4'(mo);
      b.set_year   = 12'(y);
      return b;
   endfunction

   function automatic plan_row_type beat_row(input ccc_pkg::ccc_req_type b);
      plan_row_type row;
      row      = '0;
      row.kind = STEP_BEAT;
      row.beat = b;
      return row;
   endfunction

   function automatic plan_row_type pinned_row(input ccc_pkg::ccc_req_type b,
                                               input ccc_pkg::ccc_rsp_type r);
      plan_row_type row;
      row         = beat_row(b);
      row.pinned  = 1'b1;
      row.readout = r;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic v);
      plan_row_type row;
      row        = '0;
      row.kind   = STEP_CSR;
      row.enable = v;
      return row;
   endfunction

   // mostly ticks, then sets close to a rollover, plain sets and raw bit patterns
   function automatic ccc_pkg::ccc_req_type random_beat();
      ccc_pkg::ccc_req_type b;
      logic [63:0]          raw;
      int unsigned          pick;
      raw  = {$urandom, $urandom};
      b    = ccc_pkg::ccc_req_type'(raw[$bits(ccc_pkg::ccc_req_type)-1:0]);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         // payload bits stay random, the block must ignore them
         b.req_type = ccc_pkg::REQ_TICK;
      end else if (pick < 75) begin
         b = set_beat($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                      $urandom_range(1, 28), $urandom_range(1, 12), $urandom_range(0, 4095));
      end else if (pick < 92) begin
         // a few seconds before midnight on the last or next-to-last day of a month
         b = set_beat(23, 59, $urandom_range(55, 59), 1, $urandom_range(1, 12), 0);
         case ($urandom_range(0, 3))
            0:       b.set_year = 12'hFFF;
            1:       b.set_year = 12'(ccc_pkg::CCC_EPOCH_YEAR - 2 + $urandom_range(0, 4));
            2:       b.set_year = 12'($urandom_range(0, 3));
            default: b.set_year = 12'($urandom_range(0, 4095));
         endcase
         b.set_day = 5'(month_days(b.set_month, b.set_year) - $urandom_range(0, 1));
      end else begin
         b.req_type = ccc_pkg::REQ_SET;
      end
      return b;
   endfunction

   // present one beat, hold it until taken, then maybe go quiet for a while
   task automatic offer(input ccc_pkg::ccc_req_type beat, input logic pinned,
                        input ccc_pkg::ccc_rsp_type r);
      logic taken;
      typed_readouts.push_back('{pinned, r});
      req_valid <= 1'b1;
      req_data  <= beat;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every owed readout has come back
   task automatic drain();
      if (req_valid)
         req_valid <= 1'b0;
      while (pending_readouts.size() != 0)
         @(posedge clock);
   endtask

   // run enable is only written with nothing in flight
   task automatic write_run_enable(input logic v);
      logic taken;
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // monitor: sampled mid-cycle, a handshake seen here completes at the next edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin : watch
      ccc_pkg::ccc_rsp_type want;
      ccc_pkg::ccc_rsp_type after;
      pinned_type           tag;
      if (reset === 1'b0) begin
         // results first, so a beat accepted this cycle can't match its own readout
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            results_seen++;
            if (pending_readouts.size() == 0) begin
               errors++;
               $display("%0t ns: result beat with nothing expected, actual %p", $time, rsp_data);
            end else begin
               want = pending_readouts.pop_front();
               check_field("hour", 32'(want.hour), 32'(rsp_data.hour));
               check_field("minute", 32'(want.minute), 32'(rsp_data.minute));
               check_field("second", 32'(want.second), 32'(rsp_data.second));
               check_field("day", 32'(want.day), 32'(rsp_data.day));
               check_field("month", 32'(want.month), 32'(rsp_data.month));
               check_field("year", 32'(want.year), 32'(rsp_data.year));
               check_field("seconds_of_day", 32'(want.seconds_of_day),
                           32'(rsp_data.seconds_of_day));
               check_field("day_count", 32'(want.day_count), 32'(rsp_data.day_count));
            end
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            if (req_data.req_type == ccc_pkg::REQ_SET) begin
               sets_taken++;
               after = load_time(req_data);
            end else begin
               ticks_taken++;
               // a tick while stopped still reports the current state
               after = run_on ? tick_forward(wall_clock) : wall_clock;
               if (after.day_count != wall_clock.day_count)
                  midnights++;
            end
            wall_clock = after;
            tag = '0;
            if (typed_readouts.size() != 0)
               tag = typed_readouts.pop_front();
            pending_readouts.push_back(tag.pinned ? tag.readout : after);
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            enable_writes++;
            run_on = csr_data;
         end
      end else begin
         // predictor sits at the reset state while reset is applied
         wall_clock = readout_of(0, 0, 0, 1, 1, ccc_pkg::CCC_EPOCH_YEAR, 0, 1);
         run_on     = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // result sink: random stall bursts, one long hold-off, none in the tail
   // ------------------------------------------------------------------
   initial begin : sink
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
            // long hold-off while the sender keeps offering, the block backs up
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type         plan[$];
      ccc_pkg::ccc_req_type idle_tick;
      ccc_pkg::ccc_rsp_type reset_face;
      ccc_pkg::ccc_rsp_type late_face;
      int unsigned          phase;
      int unsigned          n;
      int unsigned          beats;
      logic                 enable;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= 1'b0;

      idle_tick          = '0;
      idle_tick.req_type = ccc_pkg::REQ_TICK;
      reset_face         = readout_of(0, 0, 0, 1, 1, ccc_pkg::CCC_EPOCH_YEAR, 0, 1);
      late_face          = readout_of(23, 59, 59, 1, 1, 0, 86399, 1);

      // directed sequence, typed readouts where they are obvious
      plan.push_back(pinned_row(idle_tick, reset_face));    // stopped clock shows reset state
      plan.push_back(pinned_row(set_beat(0, 0, 0, 1, 1, ccc_pkg::CCC_EPOCH_YEAR), reset_face));
      plan.push_back(pinned_row(set_beat(23, 59, 59, 1, 1, 0), late_face));  // year below epoch
      plan.push_back(pinned_row(idle_tick, late_face));     // still stopped
      plan.push_back(csr_row(1'b1));
      plan.push_back(pinned_row(idle_tick, readout_of(0, 0, 0, 2, 1, 0, 0, 2)));
      plan.push_back(beat_row(set_beat(23, 59, 59, 31, 12, 4095)));  // top of every field
      plan.push_back(beat_row(idle_tick));                  // new year, year wraps to zero
      plan.push_back(beat_row(set_beat(23, 59, 59, 28, 2, 2028)));
      plan.push_back(beat_row(idle_tick));                  // leap february gets a 29th
      plan.push_back(beat_row(set_beat(23, 59, 59, 29, 2, 2028)));
      plan.push_back(beat_row(idle_tick));
      plan.push_back(beat_row(set_beat(23, 59, 59, 28, 2, 2027)));
      plan.push_back(beat_row(idle_tick));                  // common february ends on the 28th
      plan.push_back(beat_row(set_beat(23, 59, 59, 30, 4, 2025)));
      plan.push_back(beat_row(idle_tick));                  // thirty-day month
      plan.push_back(beat_row(set_beat(31, 63, 63, 31, 15, 4095)));  // time, month past range
      plan.push_back(beat_row(idle_tick));                  // time and day wrap at once
      plan.push_back(beat_row(set_beat(23, 59, 59, 31, 0, 2024)));  // month zero
      plan.push_back(beat_row(idle_tick));                  // day counts on modulo 32
      plan.push_back(beat_row(set_beat(12, 30, 0, 0, 13, 2100)));    // month past december
      plan.push_back(csr_row(1'b0));
      plan.push_back(beat_row(idle_tick));                  // ignored tick
      plan.push_back(csr_row(1'b1));
      plan.push_back(pinned_row(set_beat(0, 0, 0, 0, 0, 0), readout_of(0, 0, 0, 0, 0, 0, 0, 0)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_CSR)
            write_run_enable(plan[i].enable);
         else
            offer(plan[i].beat, plan[i].pinned, plan[i].readout);
      end

      // random phases, each under its own run enable setting
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1:       enable = 1'b0;
            3:       enable = 1'($urandom_range(0, 1));
            default: enable = 1'b1;
         endcase
         write_run_enable(enable);
         // last phase runs back to back on both sides
         quiet_tail = (phase == PHASES - 1);
         beats      = (phase == 1) ? 30 : 100;
         for (n = 0; n < beats; n++) begin
            // once, the sender waits until the block has handed back everything
            if (phase == 2 && n == 40)
               drain();
            offer(random_beat(), 1'b0, '0);
         end
      end

      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d request beats (%0d sets, %0d ticks), %0d results checked",
               sets_taken + ticks_taken, sets_taken, ticks_taken, results_seen);
      $display("%0d run enable writes, %0d midnight rollovers crossed", enable_writes,
               midnights);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("timeout with %0d readouts outstanding", pending_readouts.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
